### design/truncated_cone_mesh_generator_defines.svh
// ----------------------------------------------------------------------------
// truncated cone mesh generator assertion macros
// concurrent assertion wrappers, compiled out when NO_ASSERTIONS is set
// ----------------------------------------------------------------------------
`ifndef TRUNCATED_CONE_MESH_GENERATOR_DEFINES_SVH
`define TRUNCATED_CONE_MESH_GENERATOR_DEFINES_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define TCMG_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tcmg assertion failed");
// next-cycle implication
`define TCMG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tcmg assertion failed");
`else
`define TCMG_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define TCMG_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

### design/tcmg_pkg.sv
// ----------------------------------------------------------------------------
// tcmg_pkg
// shared types, constants and fixed-point helpers of the cone mesh generator
// ----------------------------------------------------------------------------
`default_nettype none

package tcmg_pkg;

    localparam logic [8:0] MAX_N = 9'd256;

    // odd quarter-sine polynomial coefficients, Q30
    localparam logic signed [31:0] SIN_COEF [5] = '{
        32'sd1686629713, -32'sd693598668, 32'sd85569306, -32'sd5026995, 32'sd172271
    };

    localparam logic signed [31:0] ONE_Q30 = 32'sd1073741824;
    localparam logic signed [15:0] ONE_Q14 = 16'sd16384;

    // constants from the setup unit: slice count reciprocals and slant normal
    typedef struct packed {
        logic [24:0]        recip;   // floor(2^24 / n)
        logic [30:0]        q30;     // floor(2^30 / n)
        logic [8:0]         rrem;    // 2^30 mod n
        logic signed [15:0] hh;      // slant normal radial scale
        logic signed [15:0] rh;      // slant normal z
    } t_slant;

    // per-item values out of the vertex pipeline
    typedef struct packed {
        logic [8:0]         idx;
        logic [14:0]        u;
        logic signed [15:0] px_t;
        logic signed [15:0] py_t;
        logic signed [15:0] px_b;
        logic signed [15:0] py_b;
        logic signed [15:0] nx;
        logic signed [15:0] ny;
    } t_geo;

    // zero acts as one, anything above the maximum as the maximum
    function automatic logic [8:0] clamp_n(input logic [8:0] v);
        logic [8:0] r;
        r = v;
        if (v == 9'd0) r = 9'd1;
        else if (v > MAX_N) r = MAX_N;
        return r;
    endfunction

    function automatic logic signed [16:0] abs16(input logic signed [15:0] v);
        logic signed [16:0] e;
        e = {v[15], v};
        return v[15] ? -e : e;
    endfunction

    // (a*b) >> 30, rounded half away from zero
    function automatic logic signed [31:0] mul_q30(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        logic [31:0] ma;
        logic [31:0] mb;
        logic [63:0] p;
        logic        neg;
        logic signed [31:0] m;
        neg = a[31] ^ b[31];
        ma  = a[31] ? 32'(-a) : 32'(a);
        mb  = b[31] ? 32'(-b) : 32'(b);
        p   = ma * mb;
        p   = p + (64'd1 << 29);
        m   = $signed(p[61:30]);
        return neg ? -m : m;
    endfunction

    // (a*b) >> 14, rounded half away from zero
    function automatic logic signed [17:0] mul_q14(input logic signed [16:0] a,
                                                   input logic signed [16:0] b);
        logic [16:0] ma;
        logic [16:0] mb;
        logic [33:0] p;
        logic        neg;
        logic signed [17:0] m;
        neg = a[16] ^ b[16];
        ma  = a[16] ? 17'(-a) : 17'(a);
        mb  = b[16] ? 17'(-b) : 17'(b);
        p   = ma * mb;
        p   = p + (34'd1 << 13);
        m   = $signed({1'b0, p[30:14]});
        return neg ? -m : m;
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
        logic signed [15:0] r;
        if (v > 18'sd32767) r = 16'sd32767;
        else if (v < -18'sd32768) r = -16'sd32768;
        else r = v[15:0];
        return r;
    endfunction

    function automatic logic signed [15:0] satq14(input logic signed [17:0] v);
        logic signed [15:0] r;
        if (v > 18'sd16384) r = ONE_Q14;
        else if (v < -18'sd16384) r = -ONE_Q14;
        else r = v[15:0];
        return r;
    endfunction

    // Q30 to Q1.14, rounded half away from zero and saturated
    function automatic logic signed [15:0] q30_to_q14(input logic signed [31:0] v);
        logic [31:0] mag;
        logic [32:0] m;
        logic [15:0] s;
        mag = v[31] ? 32'(-v) : 32'(v);
        m   = ({1'b0, mag} + 33'd32768) >> 16;
        s   = (m > 33'd16384) ? 16'd16384 : m[15:0];
        return v[31] ? -$signed(s) : $signed(s);
    endfunction

endpackage

`default_nettype wire

### design/truncated_cone_mesh_generator.sv
// ----------------------------------------------------------------------------
// truncated_cone_mesh_generator
// ring vertices, side and cap triangles of a truncated cone, one slice a item
// ----------------------------------------------------------------------------
//  channel  direction  handshake              payload
//  input    in         i_valid / o_stall      i_slice_index
//  output   out        o_valid / i_stall      o_kind .. o_last (one record)
//  config   in         psel/penable/pready    paddr, pwdata, prdata
//
//  an item passes a 14-stage pipeline, then a record serializer emits its
//  2 to 6 records one per cycle while the output does not stall; it sets
//  the rate and takes the next item as the last record is accepted (a side
//  slice with both caps has 6 records). after reset and after each register
//  write the setup unit runs one square root and up to three 44-step
//  divisions with o_stall high. an output stall freezes the serializer and,
//  once an item waits at the pipeline end, the whole pipeline.
// ----------------------------------------------------------------------------
`default_nettype none
`include "truncated_cone_mesh_generator_defines.svh"

module truncated_cone_mesh_generator import tcmg_pkg::*; (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_valid,
    output logic               o_stall,
    input  wire [8:0]          i_slice_index,
    output logic               o_valid,
    input  wire                i_stall,
    output logic               o_kind,
    output logic [9:0]         o_slot,
    output logic signed [15:0] o_pos_x,
    output logic signed [15:0] o_pos_y,
    output logic signed [15:0] o_pos_z,
    output logic signed [15:0] o_norm_x,
    output logic signed [15:0] o_norm_y,
    output logic signed [15:0] o_norm_z,
    output logic [14:0]        o_tex_u,
    output logic [14:0]        o_tex_v,
    output logic               o_last,
    input  wire                psel,
    input  wire                penable,
    input  wire                pwrite,
    input  wire [3:0]          paddr,
    input  wire [31:0]         pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam logic [1:0] REG_TOP    = 2'd0;
    localparam logic [1:0] REG_BASE   = 2'd1;
    localparam logic [1:0] REG_HEIGHT = 2'd2;
    localparam logic [1:0] REG_SLICES = 2'd3;

    localparam logic [2:0] REC_TOP   = 3'd0;
    localparam logic [2:0] REC_BASE  = 3'd1;
    localparam logic [2:0] REC_TRI_A = 3'd2;
    localparam logic [2:0] REC_TRI_B = 3'd3;
    localparam logic [2:0] REC_CAP_T = 3'd4;
    localparam logic [2:0] REC_CAP_B = 3'd5;
    localparam logic [2:0] REC_CTR_T = 3'd6;
    localparam logic [2:0] REC_CTR_B = 3'd7;

    logic signed [15:0] r_top_radius, r_base_radius, r_height;
    logic [8:0]         r_slice_count;

    logic        w_cfg_wr, w_busy, w_pv, w_pipe_en, w_ser_free, w_out_acc;
    logic [8:0]  w_n;
    t_slant      w_slant;
    t_geo        w_pgeo;

    logic        r_hv;
    logic [2:0]  r_hk;
    t_geo        r_hgeo;

    logic        w_tcap, w_bcap, w_side;
    logic [2:0]  w_cnt, w_rec;
    logic [9:0]  w_i1, w_ctop, w_cbase, w_idx, w_idx1, w_bi, w_bi1;
    logic signed [15:0] w_h2;

    // register port
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top_radius  <= 16'sd256;
            r_base_radius <= 16'sd256;
            r_height      <= 16'sd256;
            r_slice_count <= 9'd8;
        end else if (w_cfg_wr) begin
            unique case (paddr[3:2])
                REG_TOP:    r_top_radius  <= pwdata[15:0];
                REG_BASE:   r_base_radius <= pwdata[15:0];
                REG_HEIGHT: r_height      <= pwdata[15:0];
                REG_SLICES: r_slice_count <= pwdata[8:0];
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_TOP:    prdata = {16'd0, r_top_radius};
            REG_BASE:   prdata = {16'd0, r_base_radius};
            REG_HEIGHT: prdata = {16'd0, r_height};
            REG_SLICES: prdata = {23'd0, r_slice_count};
        endcase
    end

    // effective slice count
    assign w_n = clamp_n(r_slice_count);

    tcmg_setup u_setup (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (w_cfg_wr),
        .i_top_radius  (r_top_radius),
        .i_base_radius (r_base_radius),
        .i_height      (r_height),
        .i_n           (w_n),
        .o_busy        (w_busy),
        .o_slant       (w_slant)
    );

    // flow control: serializer frees up on the last record of its item
    assign w_out_acc  = o_valid && !i_stall;
    assign w_ser_free = !r_hv || (w_out_acc && o_last);
    assign w_pipe_en  = w_ser_free || !w_pv;
    assign o_stall    = w_busy || !w_pipe_en;

    tcmg_pipe u_pipe (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (w_pipe_en),
        .i_valid       (i_valid && !w_busy && (i_slice_index <= w_n)),
        .i_index       (i_slice_index),
        .i_n           (w_n),
        .i_slant       (w_slant),
        .i_top_radius  (r_top_radius),
        .i_base_radius (r_base_radius),
        .o_valid       (w_pv),
        .o_geo         (w_pgeo)
    );

    // record serializer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hv <= 1'b0;
            r_hk <= 3'd0;
        end else if (w_ser_free) begin
            r_hv <= w_pv;
            r_hk <= 3'd0;
        end else if (w_out_acc) begin
            r_hk <= r_hk + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ser_free) r_hgeo <= w_pgeo;
    end

    // record list of the held item
    assign w_tcap  = !r_top_radius[15] && (r_top_radius != 16'sd0);
    assign w_bcap  = !r_base_radius[15] && (r_base_radius != 16'sd0);
    assign w_side  = r_hgeo.idx < w_n;
    assign w_cnt   = (w_side ? 3'd4 : 3'd2) + {2'd0, w_tcap} + {2'd0, w_bcap};
    assign w_i1    = {1'b0, w_n} + 10'd1;
    assign w_ctop  = {w_i1[8:0], 1'b0};
    assign w_cbase = w_ctop + {9'd0, w_tcap};
    assign w_idx   = {1'b0, r_hgeo.idx};
    assign w_idx1  = w_idx + 10'd1;
    assign w_bi    = w_i1 + w_idx;
    assign w_bi1   = w_bi + 10'd1;
    // half height, truncated toward zero
    assign w_h2    = $signed(r_height + {15'd0, r_height[15]}) >>> 1;

    always_comb begin
        unique case (r_hk)
            3'd0: w_rec = REC_TOP;
            3'd1: w_rec = REC_BASE;
            3'd2: w_rec = w_side ? REC_TRI_A : (w_tcap ? REC_CTR_T : REC_CTR_B);
            3'd3: w_rec = w_side ? REC_TRI_B : REC_CTR_B;
            3'd4: w_rec = w_tcap ? REC_CAP_T : REC_CAP_B;
            default: w_rec = REC_CAP_B;
        endcase
    end

    // record fields
    always_comb begin
        o_kind   = 1'b1;
        o_slot   = 10'd0;
        o_pos_x  = 16'sd0;
        o_pos_y  = 16'sd0;
        o_pos_z  = 16'sd0;
        o_norm_x = 16'sd0;
        o_norm_y = 16'sd0;
        o_norm_z = 16'sd0;
        o_tex_u  = 15'd0;
        o_tex_v  = 15'd0;
        unique case (w_rec)
            REC_TOP: begin
                o_kind = 1'b0; o_slot = w_idx;
                o_pos_x = r_hgeo.px_t; o_pos_y = r_hgeo.py_t; o_pos_z = w_h2;
                o_norm_x = r_hgeo.nx; o_norm_y = r_hgeo.ny; o_norm_z = w_slant.rh;
                o_tex_u = r_hgeo.u;
            end
            REC_BASE: begin
                o_kind = 1'b0; o_slot = w_bi;
                o_pos_x = r_hgeo.px_b; o_pos_y = r_hgeo.py_b; o_pos_z = -w_h2;
                o_norm_x = r_hgeo.nx; o_norm_y = r_hgeo.ny; o_norm_z = w_slant.rh;
                o_tex_u = r_hgeo.u; o_tex_v = 15'd16384;
            end
            REC_TRI_A: begin
                o_pos_x = {6'd0, w_idx}; o_pos_y = {6'd0, w_idx1}; o_pos_z = {6'd0, w_bi};
            end
            REC_TRI_B: begin
                o_pos_x = {6'd0, w_bi}; o_pos_y = {6'd0, w_bi1}; o_pos_z = {6'd0, w_idx1};
            end
            REC_CAP_T: begin
                o_pos_x = {6'd0, w_ctop}; o_pos_y = {6'd0, w_idx}; o_pos_z = {6'd0, w_idx1};
            end
            REC_CAP_B: begin
                o_pos_x = {6'd0, w_cbase}; o_pos_y = {6'd0, w_bi}; o_pos_z = {6'd0, w_bi1};
            end
            REC_CTR_T: begin
                o_kind = 1'b0; o_slot = w_ctop; o_pos_z = w_h2; o_norm_z = ONE_Q14;
                o_tex_u = 15'd8192; o_tex_v = 15'd8192;
            end
            default: begin
                o_kind = 1'b0; o_slot = w_cbase; o_pos_z = -w_h2; o_norm_z = -ONE_Q14;
                o_tex_u = 15'd8192; o_tex_v = 15'd8192;
            end
        endcase
    end

    assign o_valid = r_hv;
    assign o_last  = r_hk == (w_cnt - 3'd1);

    // checks
    `TCMG_ASSERT_NEXT(a_write_starts_setup, i_clk, i_rst_n, w_cfg_wr, w_busy)
    `TCMG_ASSERT_IMPL(a_record_in_range, i_clk, i_rst_n, r_hv, r_hk < w_cnt)
    `TCMG_ASSERT_NEXT(a_blocked_item_kept, i_clk, i_rst_n, w_pv && !w_pipe_en, w_pv)

endmodule

`default_nettype wire

### design/tcmg_setup.sv
// ----------------------------------------------------------------------------
// tcmg_setup
// sequential unit that derives the slice reciprocals and slant normal
// ----------------------------------------------------------------------------
`default_nettype none

module tcmg_setup import tcmg_pkg::*; (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_start,
    input  wire signed [15:0]  i_top_radius,
    input  wire signed [15:0]  i_base_radius,
    input  wire signed [15:0]  i_height,
    input  wire [8:0]          i_n,
    output logic               o_busy,
    output t_slant             o_slant
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_SQRT = 3'd2;
    localparam logic [2:0] ST_DIVQ = 3'd3;
    localparam logic [2:0] ST_DIVH = 3'd4;
    localparam logic [2:0] ST_DIVR = 3'd5;

    localparam logic [5:0] SQRT_LAST = 6'd31;
    localparam logic [5:0] DIV_LAST  = 6'd43;

    logic [2:0]  r_state, n_state;
    logic [5:0]  r_cnt, n_cnt;
    logic [63:0] r_x, n_x, r_res, n_res, r_bit, n_bit;
    logic [29:0] r_rem, n_rem, r_div, n_div, r_hq, n_hq;
    logic [43:0] r_quo, n_quo;
    logic        r_neg, n_neg;
    t_slant      r_sl, n_sl;

    logic signed [16:0] w_atr, w_abr, w_r, w_habs;
    logic [15:0] w_rmag, w_hmag;
    logic [33:0] w_rsq, w_hsq;
    logic [31:0] w_s;
    logic [63:0] w_sum, w_res_nx;
    logic        w_sge;
    logic [30:0] w_trial;
    logic        w_dge;
    logic [29:0] w_rem_nx;
    logic [43:0] w_quo_nx;
    logic [14:0] w_qmag;
    logic signed [15:0] w_qsat;

    // slant length squared
    assign w_atr  = abs16(i_top_radius);
    assign w_abr  = abs16(i_base_radius);
    assign w_r    = w_atr - w_abr;
    assign w_rmag = w_r[16] ? 16'(-w_r) : w_r[15:0];
    assign w_habs = abs16(i_height);
    assign w_hmag = w_habs[15:0];
    assign w_rsq  = w_rmag * w_rmag;
    assign w_hsq  = w_hmag * w_hmag;
    assign w_s    = w_rsq[31:0] + w_hsq[31:0];

    // one square root step
    assign w_sum    = r_res + r_bit;
    assign w_sge    = r_x >= w_sum;
    assign w_res_nx = w_sge ? ((r_res >> 1) + r_bit) : (r_res >> 1);

    // one restoring division step
    assign w_trial  = {r_rem, r_quo[43]};
    assign w_dge    = w_trial >= {1'b0, r_div};
    assign w_rem_nx = w_dge ? 30'(w_trial - {1'b0, r_div}) : w_trial[29:0];
    assign w_quo_nx = {r_quo[42:0], w_dge};
    assign w_qmag   = (w_quo_nx > 44'd16384) ? 15'd16384 : w_quo_nx[14:0];
    assign w_qsat   = r_neg ? -$signed({1'b0, w_qmag}) : $signed({1'b0, w_qmag});

    // sequencer
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_x     = r_x;
        n_res   = r_res;
        n_bit   = r_bit;
        n_rem   = r_rem;
        n_div   = r_div;
        n_quo   = r_quo;
        n_hq    = r_hq;
        n_neg   = r_neg;
        n_sl    = r_sl;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) n_state = ST_MUL;
            end
            ST_MUL: begin
                n_x     = {4'd0, w_s, 28'd0};
                n_res   = 64'd0;
                n_bit   = 64'd1 << 62;
                n_cnt   = 6'd0;
                n_state = ST_SQRT;
            end
            ST_SQRT: begin
                if (w_sge) n_x = r_x - w_sum;
                n_res = w_res_nx;
                n_bit = r_bit >> 2;
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == SQRT_LAST) begin
                    n_hq    = w_res_nx[29:0];
                    n_rem   = 30'd0;
                    n_quo   = 44'd1 << 30;
                    n_div   = {21'd0, i_n};
                    n_cnt   = 6'd0;
                    n_state = ST_DIVQ;
                end
            end
            ST_DIVQ: begin
                n_rem = w_rem_nx;
                n_quo = w_quo_nx;
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == DIV_LAST) begin
                    n_sl.q30   = w_quo_nx[30:0];
                    n_sl.recip = w_quo_nx[30:6];
                    n_sl.rrem  = w_rem_nx[8:0];
                    n_cnt      = 6'd0;
                    if (r_hq == 30'd0) begin
                        n_sl.hh = 16'sd0;
                        n_sl.rh = 16'sd0;
                        n_state = ST_IDLE;
                    end else begin
                        n_rem   = 30'd0;
                        n_quo   = {w_hmag, 28'd0} + {15'd0, r_hq[29:1]};
                        n_div   = r_hq;
                        n_neg   = i_height[15];
                        n_state = ST_DIVH;
                    end
                end
            end
            ST_DIVH: begin
                n_rem = w_rem_nx;
                n_quo = w_quo_nx;
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == DIV_LAST) begin
                    n_sl.hh = w_qsat;
                    n_rem   = 30'd0;
                    n_quo   = {w_rmag, 28'd0} + {15'd0, r_hq[29:1]};
                    n_neg   = !w_r[16] && (w_r != 17'sd0);
                    n_cnt   = 6'd0;
                    n_state = ST_DIVR;
                end
            end
            ST_DIVR: begin
                n_rem = w_rem_nx;
                n_quo = w_quo_nx;
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == DIV_LAST) begin
                    n_sl.rh = w_qsat;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
        // a register write restarts the derivation from any state
        if (i_start) begin
            n_state = ST_MUL;
            n_cnt   = 6'd0;
        end
    end

    // control state, restarts the setup after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_MUL;
            r_cnt   <= 6'd0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_x   <= n_x;
        r_res <= n_res;
        r_bit <= n_bit;
        r_rem <= n_rem;
        r_div <= n_div;
        r_quo <= n_quo;
        r_hq  <= n_hq;
        r_neg <= n_neg;
        r_sl  <= n_sl;
    end

    assign o_busy  = r_state != ST_IDLE;
    assign o_slant = r_sl;

endmodule

`default_nettype wire

### design/tcmg_pipe.sv
// ----------------------------------------------------------------------------
// tcmg_pipe
// fourteen-stage pipeline: angle split, quarter sine, ring positions, normal
// ----------------------------------------------------------------------------
`default_nettype none

module tcmg_pipe import tcmg_pkg::*; (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_en,
    input  wire                i_valid,
    input  wire [8:0]          i_index,
    input  wire [8:0]          i_n,
    input  t_slant             i_slant,
    input  wire signed [15:0]  i_top_radius,
    input  wire signed [15:0]  i_base_radius,
    output logic               o_valid,
    output t_geo               o_geo
);

    localparam int NST = 14;

    typedef struct packed {
        logic [8:0]  idx;
        logic [1:0]  quad;
        logic [14:0] u;
    } t_side;

    logic [NST-1:0] r_v;
    t_side          r_sd [NST];
    t_side          w_side_c;

    // stage registers
    logic [10:0] r_b_x1;
    logic [22:0] r_b_xu;
    logic [35:0] r_b_p1;
    logic [47:0] r_b_pu;
    logic [8:0]  r_c_rem;
    logic [30:0] r_d_mq, r_e_mq;
    logic [15:0] r_d_y, r_e_y;
    logic [40:0] r_e_py;
    logic [30:0] r_f_t;
    logic signed [31:0] r_g_t, r_g_tc, r_g_t2, r_g_tc2;
    logic signed [31:0] r_h_s [4];
    logic signed [31:0] r_h_c [4];
    logic signed [31:0] r_h_t [4];
    logic signed [31:0] r_h_tc [4];
    logic signed [31:0] r_h_t2 [4];
    logic signed [31:0] r_h_tc2 [4];
    logic signed [31:0] r_j_s0, r_j_c0;
    logic signed [15:0] r_k_s, r_k_c;
    logic signed [15:0] r_l_pxt, r_l_pyt, r_l_pxb, r_l_pyb, r_l_nx, r_l_ny;

    // combinational values
    logic [10:0] w_x1;
    logic [22:0] w_xu;
    logic [11:0] w_q4e, w_rem1, w_q4;
    logic [20:0] w_prod_c;
    logic        w_gec;
    logic [23:0] w_ue;
    logic [32:0] w_produ;
    logic [22:0] w_ru;
    logic        w_geu;
    logic [39:0] w_mq;
    logic [17:0] w_y;
    logic [16:0] w_qe;
    logic [25:0] w_prodf;
    logic [15:0] w_r2;
    logic        w_gef;
    logic signed [31:0] w_t, w_tc;
    logic signed [31:0] w_acc_s [4];
    logic signed [31:0] w_acc_c [4];
    logic signed [31:0] w_ht2 [4];
    logic signed [31:0] w_htc2 [4];
    logic signed [31:0] w_qs, w_qc;
    logic signed [16:0] w_atr, w_abr, w_hh, w_c, w_s;

    // index scaling and rounded texture u
    assign w_x1 = {r_sd[0].idx, 2'b00};
    assign w_xu = {r_sd[0].idx, 14'd0} + {15'd0, i_n[8:1]};

    // quadrant and remainder of 4i/n, one correction step
    assign w_q4e    = r_b_p1[35:24];
    assign w_prod_c = w_q4e * i_n;
    assign w_rem1   = {1'b0, r_b_x1} - w_prod_c[11:0];
    assign w_gec    = w_rem1 >= {3'd0, i_n};
    assign w_q4     = w_q4e + {11'd0, w_gec};
    assign w_ue     = r_b_pu[47:24];
    assign w_produ  = w_ue * i_n;
    assign w_ru     = r_b_xu - w_produ[22:0];
    assign w_geu    = w_ru >= {14'd0, i_n};

    always_comb begin
        w_side_c      = r_sd[1];
        w_side_c.quad = w_q4[1:0];
        w_side_c.u    = w_ue[14:0] + {14'd0, w_geu};
    end

    // fraction t = rem * 2^30 / n split as rem*q30 + rem*rrem/n
    assign w_mq    = r_c_rem * i_slant.q30;
    assign w_y     = r_c_rem * i_slant.rrem;
    assign w_qe    = r_e_py[40:24];
    assign w_prodf = w_qe * i_n;
    assign w_r2    = r_e_y - w_prodf[15:0];
    assign w_gef   = w_r2 >= {7'd0, i_n};

    assign w_t  = $signed({1'b0, r_f_t});
    assign w_tc = ONE_Q30 - w_t;

    // horner operands
    always_comb begin
        w_acc_s[0] = SIN_COEF[4];
        w_acc_c[0] = SIN_COEF[4];
        w_ht2[0]   = r_g_t2;
        w_htc2[0]  = r_g_tc2;
        for (int k = 1; k < 4; k++) begin
            w_acc_s[k] = r_h_s[k-1];
            w_acc_c[k] = r_h_c[k-1];
            w_ht2[k]   = r_h_t2[k-1];
            w_htc2[k]  = r_h_tc2[k-1];
        end
    end

    // quadrant fold
    always_comb begin
        unique case (r_sd[11].quad)
            2'd0: begin w_qs = r_j_s0;  w_qc = r_j_c0;  end
            2'd1: begin w_qs = r_j_c0;  w_qc = -r_j_s0; end
            2'd2: begin w_qs = -r_j_s0; w_qc = -r_j_c0; end
            default: begin w_qs = -r_j_c0; w_qc = r_j_s0; end
        endcase
    end

    assign w_atr = abs16(i_top_radius);
    assign w_abr = abs16(i_base_radius);
    assign w_hh  = {i_slant.hh[15], i_slant.hh};
    assign w_c   = {r_k_c[15], r_k_c};
    assign w_s   = {r_k_s[15], r_k_s};

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v <= '0;
        else if (i_en) r_v <= {r_v[NST-2:0], i_valid};
    end

    // payload stages
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sd[0] <= '{idx: i_index, quad: 2'd0, u: 15'd0};
            for (int k = 1; k < NST; k++) r_sd[k] <= (k == 2) ? w_side_c : r_sd[k-1];

            r_b_x1 <= w_x1;
            r_b_xu <= w_xu;
            r_b_p1 <= w_x1 * i_slant.recip;
            r_b_pu <= w_xu * i_slant.recip;

            r_c_rem <= w_gec ? 9'(w_rem1 - {3'd0, i_n}) : w_rem1[8:0];

            r_d_mq <= w_mq[30:0];
            r_d_y  <= w_y[15:0];

            r_e_py <= r_d_y * i_slant.recip;
            r_e_mq <= r_d_mq;
            r_e_y  <= r_d_y;

            r_f_t <= r_e_mq + {14'd0, w_qe} + {30'd0, w_gef};

            r_g_t   <= w_t;
            r_g_tc  <= w_tc;
            r_g_t2  <= mul_q30(w_t, w_t);
            r_g_tc2 <= mul_q30(w_tc, w_tc);

            for (int k = 0; k < 4; k++) begin
                r_h_s[k]   <= SIN_COEF[3-k] + mul_q30(w_acc_s[k], w_ht2[k]);
                r_h_c[k]   <= SIN_COEF[3-k] + mul_q30(w_acc_c[k], w_htc2[k]);
                r_h_t2[k]  <= w_ht2[k];
                r_h_tc2[k] <= w_htc2[k];
            end
            r_h_t[0]  <= r_g_t;
            r_h_tc[0] <= r_g_tc;
            for (int k = 1; k < 4; k++) begin
                r_h_t[k]  <= r_h_t[k-1];
                r_h_tc[k] <= r_h_tc[k-1];
            end

            r_j_s0 <= mul_q30(r_h_s[3], r_h_t[3]);
            r_j_c0 <= mul_q30(r_h_c[3], r_h_tc[3]);

            r_k_s <= q30_to_q14(w_qs);
            r_k_c <= q30_to_q14(w_qc);

            r_l_pxt <= sat16(mul_q14(w_atr, w_c));
            r_l_pyt <= sat16(mul_q14(w_atr, w_s));
            r_l_pxb <= sat16(mul_q14(w_abr, w_c));
            r_l_pyb <= sat16(mul_q14(w_abr, w_s));
            r_l_nx  <= satq14(mul_q14(w_hh, w_c));
            r_l_ny  <= satq14(mul_q14(w_hh, w_s));
        end
    end

    assign o_valid = r_v[NST-1];
    assign o_geo   = '{idx: r_sd[NST-1].idx, u: r_sd[NST-1].u,
                       px_t: r_l_pxt, py_t: r_l_pyt, px_b: r_l_pxb, py_b: r_l_pyb,
                       nx: r_l_nx, ny: r_l_ny};

endmodule

`default_nettype wire
